/* src/polygon_winding_number_unit_assert.svh */
// assertion macros for the winding number unit checker
// depends on clk and rst being visible where the macros are used
`ifndef POLYGON_WINDING_NUMBER_UNIT_ASSERT_SVH
`define POLYGON_WINDING_NUMBER_UNIT_ASSERT_SVH

// same-cycle implication, reset disables
`define PWN_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset disables
`define PWN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pwn_pkg.sv */
// shared types and constants of the polygon winding number unit
// no dependencies
package pwn_pkg;

  localparam int WIND_BITS     = 12;
  localparam int OUT_DATA_BITS = 16;

  localparam logic signed [WIND_BITS-1:0] WIND_MAX = 12'sh7FF;
  localparam logic signed [WIND_BITS-1:0] WIND_MIN = 12'sh800;

  // what the back end does with one edge
  typedef logic [1:0] edge_kind_t;
  localparam edge_kind_t KIND_CLEAR = 2'd0;
  localparam edge_kind_t KIND_NONE  = 2'd1;
  localparam edge_kind_t KIND_UP    = 2'd2;
  localparam edge_kind_t KIND_DOWN  = 2'd3;

  typedef struct packed {
    edge_kind_t kind;
    logic       last;
  } edge_ctl_t;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_X = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_Y = 1'b1;

endpackage

/* src/pwn_queue.sv */
// small register queue between front and back end
// no package dependencies
module pwn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign full     = (count == (PTR_BITS+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/pwn_front.sv */
// front end: takes vertices, keeps the previous one, classifies each edge
// depends on pwn_pkg
module pwn_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         first_vertex,
  input  logic                         last_vertex,
  output logic                         q_push,
  input  logic                         q_full,
  output pwn_pkg::edge_ctl_t           q_ctl,
  output logic signed [COORD_BITS:0]   q_dx,
  output logic signed [COORD_BITS:0]   q_dy,
  output logic signed [COORD_BITS:0]   q_ex,
  output logic signed [COORD_BITS:0]   q_ey
);

  import pwn_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic                         have_prev;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // edge vector and point offset from the edge start, one bit wider
  assign q_dx = DW'(vertex_x) - DW'(prev_x);
  assign q_dy = DW'(vertex_y) - DW'(prev_y);
  assign q_ex = DW'(point_x) - DW'(prev_x);
  assign q_ey = DW'(point_y) - DW'(prev_y);

  always_comb begin
    q_ctl.last = last_vertex;
    if (first_vertex || !have_prev) begin
      q_ctl.kind = KIND_CLEAR;
    end else if (prev_y <= point_y) begin
      q_ctl.kind = (vertex_y > point_y) ? KIND_UP : KIND_NONE;
    end else begin
      q_ctl.kind = (vertex_y <= point_y) ? KIND_DOWN : KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else if (q_push) begin
      have_prev <= !last_vertex;
      prev_x    <= vertex_x;
      prev_y    <= vertex_y;
    end
  end

endmodule

/* src/pwn_back.sv */
// back end: cross product stage, saturating winding count, result register
// depends on pwn_pkg
module pwn_back #(
  parameter int COORD_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_empty,
  output logic                                    q_pop,
  input  pwn_pkg::edge_ctl_t                      q_ctl,
  input  logic signed [COORD_BITS:0]              q_dx,
  input  logic signed [COORD_BITS:0]              q_dy,
  input  logic signed [COORD_BITS:0]              q_ex,
  input  logic signed [COORD_BITS:0]              q_ey,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pwn_pkg::WIND_BITS-1:0]    winding,
  output logic                                    inside_res
);

  import pwn_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic                        s1_valid;
  edge_ctl_t                   s1_ctl;
  logic signed [PW-1:0]        s1_pa;
  logic signed [PW-1:0]        s1_pb;
  logic signed [SW-1:0]        xprod;
  logic                        xprod_pos;
  logic                        xprod_neg;
  logic signed [WIND_BITS-1:0] wind;
  logic signed [WIND_BITS-1:0] wind_next;
  logic                        stall;

  // only a closing edge needs the result register free
  assign stall = s1_valid && s1_ctl.last && out_valid && !out_ready;
  assign q_pop = !q_empty && !stall;

  assign xprod     = SW'(s1_pa) - SW'(s1_pb);
  assign xprod_neg = xprod[SW-1];
  assign xprod_pos = !xprod[SW-1] && (xprod != '0);

  always_comb begin
    wind_next = wind;
    case (s1_ctl.kind)
      KIND_CLEAR: wind_next = '0;
      KIND_UP: begin
        if (xprod_pos && (wind != WIND_MAX)) begin
          wind_next = wind + WIND_BITS'(1);
        end
      end
      KIND_DOWN: begin
        if (xprod_neg && (wind != WIND_MIN)) begin
          wind_next = wind - WIND_BITS'(1);
        end
      end
      default: wind_next = wind;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      wind      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!stall && s1_valid && s1_ctl.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (!stall) begin
        s1_valid <= q_pop;
        if (s1_valid) begin
          if (s1_ctl.last) begin
            wind <= '0;
          end else begin
            wind <= wind_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_ctl <= q_ctl;
      s1_pa  <= q_dx * q_ey;
      s1_pb  <= q_ex * q_dy;
      if (s1_valid && s1_ctl.last) begin
        winding    <= wind_next;
        inside_res <= (wind_next != '0);
      end
    end
  end

endmodule

/* src/polygon_winding_number_unit.sv */
// top level of the polygon winding number unit
// depends on pwn_pkg, pwn_front, pwn_queue, pwn_back
//
// usage
//   set the test point through the cfg channel (index 0 point x, index 1 point y)
//   while the unit is idle; cfg_ready is always high
//   stream polygon vertices on the s_ channel, one per transaction:
//   s_tdata holds vertex x and y, s_tuser marks the first vertex of a polygon,
//   s_tlast marks the closing vertex, which repeats the first one
//   each closing vertex gives one m_ transaction: the saturated winding number
//   and an inside flag
// timing
//   one vertex per cycle while the queue has room; the front end and the back end each
//   take one item per cycle unless stalled, the back end multiplier stage is fully pipelined
//   a closing vertex reaches m_tvalid through the queue, the s1 stage and the result register
// stall
//   a held result only stops the back end when the next closing vertex reaches
//   it; vertices keep flowing into the QUEUE_DEPTH entry queue until it fills,
//   then s_tready drops
// reset
//   rst clears the point, the open polygon, the queue and the result valid flag
module polygon_winding_number_unit #(
  parameter int COORD_BITS  = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pwn_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]                   cfg_data,
  // vertex stream
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,  // vertex_x, vertex_y
  input  logic [0:0]                              s_tuser,  // first_vertex
  input  logic                                    s_tlast,  // last_vertex
  // result stream
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [pwn_pkg::OUT_DATA_BITS-1:0]       m_tdata   // winding, inside_res
);

  import pwn_pkg::*;

  localparam int DW       = COORD_BITS + 1;
  localparam int Q_WIDTH  = $bits(edge_ctl_t) + 4 * DW;
  localparam int PAD_BITS = OUT_DATA_BITS - WIND_BITS - 1;

  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  // front to queue
  logic                  f_push;
  logic                  q_full;
  edge_ctl_t             f_ctl;
  logic signed [DW-1:0]  f_dx;
  logic signed [DW-1:0]  f_dy;
  logic signed [DW-1:0]  f_ex;
  logic signed [DW-1:0]  f_ey;

  // queue to back
  logic                  q_empty;
  logic                  b_pop;
  logic [Q_WIDTH-1:0]    q_rd;
  edge_ctl_t             b_ctl;
  logic signed [DW-1:0]  b_dx;
  logic signed [DW-1:0]  b_dy;
  logic signed [DW-1:0]  b_ex;
  logic signed [DW-1:0]  b_ey;

  logic signed [WIND_BITS-1:0] winding;
  logic                        inside_res;

  // test point registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_x <= '0;
      point_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POINT_X: point_x <= cfg_data;
        CFG_POINT_Y: point_y <= cfg_data;
        default: ;
      endcase
    end
  end

  pwn_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .point_x      (point_x),
    .point_y      (point_y),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .vertex_x     (s_tdata[COORD_BITS-1:0]),
    .vertex_y     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .first_vertex (s_tuser[0]),
    .last_vertex  (s_tlast),
    .q_push       (f_push),
    .q_full       (q_full),
    .q_ctl        (f_ctl),
    .q_dx         (f_dx),
    .q_dy         (f_dy),
    .q_ex         (f_ex),
    .q_ey         (f_ey)
  );

  // edge queue decouples classification from the arithmetic
  pwn_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_ctl, f_dx, f_dy, f_ex, f_ey}),
    .full      (q_full),
    .pop       (b_pop),
    .pop_data  (q_rd),
    .empty     (q_empty)
  );

  assign {b_ctl, b_dx, b_dy, b_ex, b_ey} = q_rd;

  pwn_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (b_pop),
    .q_ctl      (b_ctl),
    .q_dx       (b_dx),
    .q_dy       (b_dy),
    .q_ex       (b_ex),
    .q_ey       (b_ey),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .winding    (winding),
    .inside_res (inside_res)
  );

  // result word: winding in the low bits, inside flag above it
  assign m_tdata = {{PAD_BITS{1'b0}}, inside_res, winding};

endmodule

/* src/polygon_winding_number_unit_checker.sv */
// port-level checker for the polygon winding number unit, bound to the top
// depends on polygon_winding_number_unit_assert.svh and the top level
`include "polygon_winding_number_unit_assert.svh"

module polygon_winding_number_unit_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a pending result transaction holds until taken
  `PWN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

  // inside flag agrees with the winding number
  `PWN_ASSERT_SAME(a_inside_flag, m_tvalid, m_tdata[12] == (m_tdata[11:0] != 12'd0), "inside flag disagrees with winding")

  // no result right after reset
  `PWN_ASSERT_SAME(a_reset_quiet, $past(rst), !m_tvalid, "result present right after reset")

  // configuration is never back-pressured
  `PWN_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind polygon_winding_number_unit polygon_winding_number_unit_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
